/* rtl/sczx_pkg.sv */
// Package for the sprite chain zoom expander.
// Holds field widths, packed stream layouts and the result record type.
// No dependencies.
package sczx_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned CoordW = 10;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PalW   = 10;
  localparam int unsigned PosW   = 14;
  localparam int unsigned SizeW  = 5;
  localparam int unsigned ProdW  = 17;
  localparam int unsigned OffW   = 12;

  localparam int unsigned InDataW  = 6 * WordW;
  localparam int unsigned OutBitsW = WordW + PalW + 2 + 2 * PosW + 2 * SizeW;
  localparam int unsigned OutDataW = ((OutBitsW + 7) / 8) * 8;

  localparam logic [ByteW-1:0] ZoomFull  = 8'hff;
  localparam logic [8:0]       ZoomScale = 9'h100;
  localparam logic [3:0]       RoundUp   = 4'hf;

  typedef struct packed {
    logic [WordW-1:0]       code_out;
    logic [PalW-1:0]        palette_base;
    logic                   flip_x;
    logic                   flip_y;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic [SizeW-1:0]       size_x;
    logic [SizeW-1:0]       size_y;
    logic                   zoomed;
  } draw_cmd_t;

  // Drawn size of a lone sprite on one axis: (256 - zoom) / 16.
  function automatic logic [SizeW-1:0] lone_size(input logic [ByteW-1:0] zoom);
    logic [8:0] span;
    span = ZoomScale - {1'b0, zoom};
    return span[8:4];
  endfunction

endpackage

/* rtl/sprite_chain_zoom_expander.sv */
// Sprite chain zoom expander: turns sprite-list entries into draw commands.
// Depends on sczx_pkg.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata entry words, s_tuser frame_start
//  m_      | out | m_tvalid/m_tready  | m_tdata draw command, m_tuser zoomed
//
// One entry is taken per cycle while the skid is empty. Its command is registered
// in the output register, or in the skid if the output is stalled. Chain state and
// the command are computed in the same cycle the entry is accepted, with one 8x8
// multiply per axis setting the piece offset. The output and skid registers let the
// input take one entry in an output stall. Synchronous reset clears control state.
module sprite_chain_zoom_expander
  import sczx_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // tile_code, attr_word, x_word, y_word, zoom_word, size_word (lowest first)
  input  logic [InDataW-1:0]  s_tdata,
  // frame_start
  input  logic [0:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // code_out, palette_base, flip_x, flip_y, pos_x, pos_y, size_x, size_y, zero pad
  output logic [OutDataW-1:0] m_tdata,
  // zoomed
  output logic [0:0]          m_tuser
);

  logic [WordW-1:0] tile_code, attr_word, x_word, y_word, zoom_word, size_word;
  logic             frame_start;

  assign tile_code   = s_tdata[15:0];
  assign attr_word   = s_tdata[31:16];
  assign x_word      = s_tdata[47:32];
  assign y_word      = s_tdata[63:48];
  assign zoom_word   = s_tdata[79:64];
  assign size_word   = s_tdata[95:80];
  assign frame_start = s_tuser[0];

  // Chain state.
  logic              in_chain, in_chain_next;
  logic [CoordW-1:0] anchor_x, anchor_x_next, anchor_y, anchor_y_next;
  logic [ByteW-1:0]  column_index, column_index_next, row_index, row_index_next;
  logic [ByteW-1:0]  last_column, last_column_next, last_row, last_row_next;
  logic [ByteW-1:0]  held_zoom_x, held_zoom_x_next, held_zoom_y, held_zoom_y_next;

  // Output buffer.
  draw_cmd_t out_cmd, skid_cmd, cmd_next;
  logic      skid_valid;

  logic accept_in, take_out;
  assign s_tready  = !skid_valid;
  assign accept_in = s_tvalid && s_tready;
  assign take_out  = m_tvalid && m_tready;

  logic             chain_live, start_chain, chain_now;
  logic [ByteW-1:0] zoom_x_in, zoom_y_in, step_x, step_y;
  logic [ProdW-1:0] prod_x, prod_y, end_x, end_y;
  logic [OffW-1:0]  off_x, off_y, off_x_end, off_y_end;
  logic [OffW-1:0]  size_x_full, size_y_full;

  always_comb begin
    zoom_x_in  = zoom_word[15:8];
    zoom_y_in  = zoom_word[7:0];
    chain_live = in_chain && !frame_start;
    start_chain = (size_word != '0) && !chain_live;
    chain_now  = chain_live || start_chain;

    // Effective chain registers for this entry.
    if (start_chain) begin
      last_column_next = size_word[15:8];
      last_row_next    = size_word[7:0];
      column_index_next = '0;
      row_index_next   = '0;
      anchor_x_next    = x_word[CoordW-1:0];
      anchor_y_next    = y_word[CoordW-1:0];
      held_zoom_x_next = zoom_x_in;
      held_zoom_y_next = zoom_y_in;
    end else begin
      last_column_next = last_column;
      last_row_next    = last_row;
      column_index_next = column_index;
      row_index_next   = row_index;
      anchor_x_next    = anchor_x;
      anchor_y_next    = anchor_y;
      held_zoom_x_next = held_zoom_x;
      held_zoom_y_next = held_zoom_y;
    end

    // Piece offsets: off(n) = (n*(255-zoom)+15)/16, and off(n+1) from the same product.
    step_x    = ZoomFull - held_zoom_x_next;
    step_y    = ZoomFull - held_zoom_y_next;
    prod_x    = {{(ProdW-ByteW){1'b0}}, column_index_next}
                * {{(ProdW-ByteW){1'b0}}, step_x};
    prod_y    = {{(ProdW-ByteW){1'b0}}, row_index_next}
                * {{(ProdW-ByteW){1'b0}}, step_y};
    off_x     = OffW'((prod_x + ProdW'(RoundUp)) >> 4);
    off_y     = OffW'((prod_y + ProdW'(RoundUp)) >> 4);
    end_x     = prod_x + ProdW'(step_x) + ProdW'(RoundUp);
    end_y     = prod_y + ProdW'(step_y) + ProdW'(RoundUp);
    off_x_end = OffW'(end_x >> 4);
    off_y_end = OffW'(end_y >> 4);
    size_x_full = off_x_end - off_x;
    size_y_full = off_y_end - off_y;

    cmd_next.code_out     = tile_code;
    cmd_next.palette_base = {attr_word[5:0], 4'b0000};
    cmd_next.flip_x       = attr_word[14];
    cmd_next.flip_y       = attr_word[15];

    if (chain_now) begin
      cmd_next.pos_x  = {{(PosW-CoordW){anchor_x_next[CoordW-1]}}, anchor_x_next}
                        + {{(PosW-OffW){1'b0}}, off_x};
      cmd_next.pos_y  = {{(PosW-CoordW){anchor_y_next[CoordW-1]}}, anchor_y_next}
                        + {{(PosW-OffW){1'b0}}, off_y};
      cmd_next.size_x = size_x_full[SizeW-1:0];
      cmd_next.size_y = size_y_full[SizeW-1:0];
      cmd_next.zoomed = (held_zoom_x_next != '0) || (held_zoom_y_next != '0);
    end else begin
      cmd_next.pos_x  = {{(PosW-CoordW){x_word[CoordW-1]}}, x_word[CoordW-1:0]};
      cmd_next.pos_y  = {{(PosW-CoordW){y_word[CoordW-1]}}, y_word[CoordW-1:0]};
      cmd_next.size_x = lone_size(zoom_x_in);
      cmd_next.size_y = lone_size(zoom_y_in);
      cmd_next.zoomed = (zoom_x_in != '0) || (zoom_y_in != '0);
    end

    // Row counter is the inner loop, column counter the outer one.
    in_chain_next = chain_now;
    if (chain_now) begin
      if (row_index_next >= last_row_next) begin
        row_index_next = '0;
        if (column_index_next >= last_column_next) begin
          in_chain_next     = 1'b0;
          column_index_next = '0;
        end else begin
          column_index_next = column_index_next + 1'b1;
        end
      end else begin
        row_index_next = row_index_next + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_chain     <= 1'b0;
      anchor_x     <= '0;
      anchor_y     <= '0;
      column_index <= '0;
      row_index    <= '0;
      last_column  <= '0;
      last_row     <= '0;
      held_zoom_x  <= '0;
      held_zoom_y  <= '0;
    end else if (accept_in) begin
      in_chain     <= in_chain_next;
      anchor_x     <= anchor_x_next;
      anchor_y     <= anchor_y_next;
      column_index <= column_index_next;
      row_index    <= row_index_next;
      last_column  <= last_column_next;
      last_row     <= last_row_next;
      held_zoom_x  <= held_zoom_x_next;
      held_zoom_y  <= held_zoom_y_next;
    end
  end

  // A new command goes to the output register when it is free or being drained,
  // otherwise into the skid register, which drains first.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take_out) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept_in;
      end
    end else if (accept_in) begin
      if (m_tvalid) begin
        skid_valid <= 1'b1;
      end else begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_out && skid_valid) begin
      out_cmd <= skid_cmd;
    end else if (accept_in && (take_out || !m_tvalid)) begin
      out_cmd <= cmd_next;
    end
    if (accept_in && m_tvalid && !take_out) begin
      skid_cmd <= cmd_next;
    end
  end

  assign m_tdata = {{(OutDataW-OutBitsW){1'b0}},
                    out_cmd.size_y, out_cmd.size_x, out_cmd.pos_y, out_cmd.pos_x,
                    out_cmd.flip_y, out_cmd.flip_x, out_cmd.palette_base,
                    out_cmd.code_out};
  assign m_tuser = out_cmd.zoomed;

  // The skid register only fills behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid register holds a command while the output register is empty");

  // A drawn piece never exceeds one 16-pixel cell on either axis.
  a_piece_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_cmd.size_x <= 5'd16) && (out_cmd.size_y <= 5'd16))
    else $error("piece size exceeds one cell");

  // Chain state moves only when an entry is taken.
  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    !accept_in |=> $stable(in_chain) && $stable(row_index) && $stable(column_index))
    else $error("chain state changed without an accepted entry");

  // An entry taken behind a stalled output never leaves the input ready next cycle.
  a_ready_skid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && accept_in) |=> !s_tready || !m_tvalid)
    else $error("input stayed ready with a full output buffer");

endmodule

/* test/tb_sprite_chain_zoom_expander.sv */
// Self-checking testbench for the sprite chain zoom expander.
// Drives sprite-list entries on the input stream and checks every draw command
// against a behavioral predictor; depends on sczx_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_sprite_chain_zoom_expander;
  import sczx_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic             frame_start;
    logic [WordW-1:0] tile_code;
    logic [WordW-1:0] attr_word;
    logic [WordW-1:0] x_word;
    logic [WordW-1:0] y_word;
    logic [WordW-1:0] zoom_word;
    logic [WordW-1:0] size_word;
  } sprite_entry_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [0:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [0:0]          m_tuser;

  sprite_chain_zoom_expander dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Predictor copy of the big-sprite chain state.
  logic             chain_active;
  logic [9:0]       anchor_x, anchor_y;
  logic [ByteW-1:0] col_idx, row_idx, col_last, row_last;
  logic [ByteW-1:0] chain_zoom_x, chain_zoom_y;

  draw_cmd_t   pending_cmds[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;
  int unsigned rx_gap = 0;
  int unsigned rx_hold = 0;

  function automatic int coord_value(input logic [9:0] v);
    return int'(signed'(v));
  endfunction

  // Rounded-up offset of piece n along one axis of a chain.
  function automatic int unsigned piece_offset(input int unsigned n, input logic [7:0] zoom);
    return (n * (32'd255 - 32'(zoom)) + 32'd15) / 32'd16;
  endfunction

  function automatic void clear_chain_state();
    chain_active = 1'b0;
    anchor_x = '0;
    anchor_y = '0;
    col_idx = '0;
    row_idx = '0;
    col_last = '0;
    row_last = '0;
    chain_zoom_x = '0;
    chain_zoom_y = '0;
  endfunction

  function automatic draw_cmd_t predict_draw_cmd(input sprite_entry_t e);
    draw_cmd_t        cmd;
    logic [ByteW-1:0] zx, zy;
    int               px, py;
    int unsigned      ox, oy, sx, sy;
    zx = e.zoom_word[15:8];
    zy = e.zoom_word[7:0];
    if (e.frame_start) clear_chain_state();
    if (e.size_word != '0 && !chain_active) begin
      col_last = e.size_word[15:8];
      row_last = e.size_word[7:0];
      col_idx = '0;
      row_idx = '0;
      anchor_x = e.x_word[9:0];
      anchor_y = e.y_word[9:0];
      chain_zoom_x = zx;
      chain_zoom_y = zy;
      chain_active = 1'b1;
    end
    if (chain_active) begin
      ox = piece_offset(int'(col_idx), chain_zoom_x);
      oy = piece_offset(int'(row_idx), chain_zoom_y);
      px = coord_value(anchor_x) + int'(ox);
      py = coord_value(anchor_y) + int'(oy);
      sx = piece_offset(int'(col_idx) + 1, chain_zoom_x) - ox;
      sy = piece_offset(int'(row_idx) + 1, chain_zoom_y) - oy;
      zx = chain_zoom_x;
      zy = chain_zoom_y;
      // Rows are the inner loop; the chain ends after the last column.
      if (row_idx >= row_last) begin
        row_idx = '0;
        if (col_idx >= col_last) begin
          chain_active = 1'b0;
          col_idx = '0;
        end else begin
          col_idx = col_idx + 1'b1;
        end
      end else begin
        row_idx = row_idx + 1'b1;
      end
    end else begin
      px = coord_value(e.x_word[9:0]);
      py = coord_value(e.y_word[9:0]);
      sx = (32'd256 - 32'(zx)) / 32'd16;
      sy = (32'd256 - 32'(zy)) / 32'd16;
    end
    cmd.code_out = e.tile_code;
    cmd.palette_base = {e.attr_word[5:0], 4'b0000};
    cmd.flip_x = e.attr_word[14];
    cmd.flip_y = e.attr_word[15];
    cmd.pos_x = PosW'(px);
    cmd.pos_y = PosW'(py);
    cmd.size_x = SizeW'(sx);
    cmd.size_y = SizeW'(sy);
    cmd.zoomed = (zx != '0) || (zy != '0);
    return cmd;
  endfunction

  function automatic sprite_entry_t entry_of(input logic fs, input logic [15:0] code,
                                             input logic [15:0] attr, input logic [15:0] xw,
                                             input logic [15:0] yw, input logic [15:0] zw,
                                             input logic [15:0] sw);
    sprite_entry_t e;
    e.frame_start = fs;
    e.tile_code = code;
    e.attr_word = attr;
    e.x_word = xw;
    e.y_word = yw;
    e.zoom_word = zw;
    e.size_word = sw;
    return e;
  endfunction

  function automatic sprite_entry_t make_entry(input logic fs, input logic [15:0] sw);
    logic [15:0] zw;
    zw = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
    return entry_of(fs, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), zw, sw);
  endfunction

  // Size word carried by a piece inside a chain, where it has no effect.
  function automatic logic [15:0] junk_size();
    return ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'h0000;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("%0t: %s", $realtime, what);
  endtask

  // Offer one entry; returns at the falling edge after the transaction.
  task automatic send_entry(input sprite_entry_t e);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {e.size_word, e.zoom_word, e.y_word, e.x_word, e.attr_word, e.tile_code};
    s_tuser <= e.frame_start;
    do @(posedge clk); while (!s_tready);
    pending_cmds.push_back(predict_draw_cmd(e));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
  endtask

  // Result checker; m_tdata holds code, palette, flips, positions and sizes from bit 0 up.
  always @(posedge clk) begin
    draw_cmd_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.code_out = m_tdata[15:0];
      got.palette_base = m_tdata[25:16];
      got.flip_x = m_tdata[26];
      got.flip_y = m_tdata[27];
      got.pos_x = m_tdata[41:28];
      got.pos_y = m_tdata[55:42];
      got.size_x = m_tdata[60:56];
      got.size_y = m_tdata[65:61];
      got.zoomed = m_tuser[0];
      if (pending_cmds.size() == 0) begin
        note_mismatch($sformatf("draw command with nothing expected: %p", got));
      end else begin
        want = pending_cmds.pop_front();
        if (got.code_out !== want.code_out || got.palette_base !== want.palette_base ||
            got.flip_x !== want.flip_x || got.flip_y !== want.flip_y ||
            got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.size_x !== want.size_x || got.size_y !== want.size_y ||
            got.zoomed !== want.zoomed)
          note_mismatch($sformatf("draw command mismatch\n  expected %p\n  actual   %p",
                                  want, got));
      end
      rx_gap = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  // Output-side ready, with per-transaction gaps and long hold-offs on request.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_lone_sprites();
    send_entry(entry_of(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_entry(entry_of(1'b0, 16'hffff, 16'hffff, 16'h01ff, 16'h03ff, 16'hffff, 16'h0000));
    send_entry(entry_of(1'b0, 16'h1234, 16'hc03f, 16'h0200, 16'hfe00, 16'h00ff, 16'h0000));
    send_entry(entry_of(1'b0, 16'h8001, 16'h3fc0, 16'hfc00, 16'h7c01, 16'hff00, 16'h0000));
    send_entry(entry_of(1'b0, 16'h5a5a, 16'h4015, 16'h0155, 16'h02aa, 16'h1080, 16'h0000));
  endtask

  task automatic test_directed_chains();
    // Two by two chain anchored at the most negative corner; pieces carry junk.
    send_entry(entry_of(1'b0, 16'h0100, 16'h0007, 16'h0200, 16'h0200, 16'h4020, 16'h0101));
    send_entry(entry_of(1'b0, 16'h0101, 16'h8000, 16'h0123, 16'h0321, 16'h0000, 16'hffff));
    send_entry(entry_of(1'b0, 16'h0102, 16'h4000, 16'hffff, 16'hffff, 16'hffff, 16'h0001));
    send_entry(entry_of(1'b0, 16'h0103, 16'h003f, 16'h0000, 16'h0000, 16'h0000, 16'h0100));
    // Fully shrunk column of three rows: every piece has zero size.
    send_entry(entry_of(1'b0, 16'h0200, 16'hffff, 16'h03ff, 16'h01ff, 16'hffff, 16'h0002));
    send_entry(entry_of(1'b0, 16'h0201, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_entry(entry_of(1'b0, 16'h0202, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // Unzoomed row of two columns near the positive edge.
    send_entry(entry_of(1'b0, 16'h0300, 16'h0011, 16'h01ff, 16'h01ff, 16'h0000, 16'h0100));
    send_entry(entry_of(1'b0, 16'h0301, 16'h0022, 16'h0000, 16'h0000, 16'h8888, 16'h0000));
    // A frame start in the middle of a chain drops it and may start another.
    send_entry(entry_of(1'b0, 16'h0400, 16'h0033, 16'h0010, 16'h0020, 16'h8080, 16'h0303));
    send_entry(entry_of(1'b0, 16'h0401, 16'h0033, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_entry(entry_of(1'b1, 16'h0402, 16'h0034, 16'h0305, 16'h0001, 16'h00c0, 16'h0001));
    send_entry(entry_of(1'b0, 16'h0403, 16'h0035, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_entry(entry_of(1'b1, 16'h0404, 16'h0036, 16'h0077, 16'h0088, 16'h2000, 16'h0000));
  endtask

  // Single-row and single-column chains of the largest length.
  task automatic test_widest_chains();
    send_entry(make_entry(1'b1, 16'hff00));
    repeat (255) send_entry(make_entry(1'b0, junk_size()));
    send_entry(make_entry(1'b0, 16'h00ff));
    repeat (255) send_entry(make_entry(1'b0, junk_size()));
  endtask

  task automatic test_random_lists(input int unsigned count);
    int unsigned sent, pick, cols, rows, pieces;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_entry(make_entry(1'b1, ($urandom_range(0, 1) != 0) ? 16'h0000 :
                              {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))}));
        sent++;
      end else if (pick < 55) begin
        cols = $urandom_range(0, 3);
        rows = $urandom_range(0, 3);
        if (cols == 0 && rows == 0) rows = 1;
        send_entry(make_entry(1'b0, {8'(cols), 8'(rows)}));
        pieces = (cols + 1) * (rows + 1) - 1;
        // Now and then a frame start breaks the chain early.
        for (int unsigned i = 0; i < pieces; i++)
          send_entry(make_entry($urandom_range(0, 19) == 0, junk_size()));
        sent += pieces + 1;
      end else if (pick < 60) begin
        send_entry(make_entry($urandom_range(0, 7) == 0, 16'($urandom)));
        sent++;
      end else begin
        send_entry(make_entry(1'b0, 16'h0000));
        sent++;
      end
    end
  endtask

  task automatic test_output_stall();
    rx_hold = 400;
    test_random_lists(40);
    wait_drain();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_lists(200);
    wait_drain();
    idle_on = 1'b1;
  endtask

  initial begin
    clear_chain_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_lone_sprites();
    test_directed_chains();
    test_widest_chains();
    test_random_lists(850);
    test_output_stall();
    test_back_to_back();
    test_random_lists(50);
    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sprite_chain_zoom_expander.f */
rtl/sczx_pkg.sv
rtl/sprite_chain_zoom_expander.sv
test/tb_sprite_chain_zoom_expander.sv
